### rtl/core/ncc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncc_pkg
// Shared types and constants for the nearest color classifier.
// ----------------------------------------------------------------------------
package ncc_pkg;

  localparam int DEF_NUM_REFS       = 6;
  localparam int DEF_COMPONENT_BITS = 16;

  localparam int COMP_W = 16;
  localparam int CONF_W = 17;
  localparam int CNT_W  = 3;
  localparam int IDX_W  = 3;
  localparam int CFG_W  = 48;
  localparam int MAG_W  = 18;
  localparam int SQ_W   = 32;
  localparam int ACC_W  = 34;
  localparam int STEP_W = 5;

  localparam logic [CONF_W-1:0] Q16_ONE    = 17'h10000;
  localparam logic [CONF_W-1:0] THR_RESET  = 17'd62259;
  localparam logic [ACC_W-1:0]  BEST_RESET = 34'h2_0000_0000;

  localparam logic [IDX_W-1:0] REG_REF_COUNT   = 3'd0;
  localparam logic [IDX_W-1:0] REG_THRESHOLD   = 3'd1;
  localparam logic [IDX_W-1:0] REG_REF_COLOR_0 = 3'd2;

  localparam logic [STEP_W-1:0] DRAIN_STEPS = 5'd3;
  localparam logic [STEP_W-1:0] SQRT_STEPS  = 5'd16;
  localparam logic [STEP_W-1:0] DIV_STEPS   = 5'd17;

  typedef enum logic [1:0] {
    COMP_RED,
    COMP_GREEN,
    COMP_BLUE
  } comp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SEARCH,
    ST_DRAIN,
    ST_PREP,
    ST_SQRT,
    ST_CHECK,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             load;
    logic             issue;
    logic [CNT_W-1:0] ref_sel;
    comp_t            comp_sel;
    logic             sqrt_load;
    logic             sqrt_step;
    logic             check;
    logic             div_step;
    logic             result_load;
  } cmd_t;

  typedef struct packed {
    logic             empty;
    logic             found;
    logic             out_free;
    logic [CNT_W-1:0] count;
  } status_t;

endpackage

### rtl/core/ncc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncc_ctrl
// Sequencer: steps the table search, square root, divide and result hand-off.
// ----------------------------------------------------------------------------
module ncc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             pixel_valid,
  output logic             pixel_ready,
  input  ncc_pkg::status_t status,
  output ncc_pkg::cmd_t    cmd
);

  ncc_pkg::state_t                 state, state_next;
  logic [ncc_pkg::CNT_W-1:0]       ri, ri_next;
  ncc_pkg::comp_t                  cc, cc_next;
  logic [ncc_pkg::STEP_W-1:0]      step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ncc_pkg::ST_IDLE;
      ri    <= '0;
      cc    <= ncc_pkg::COMP_RED;
      step  <= '0;
    end else begin
      state <= state_next;
      ri    <= ri_next;
      cc    <= cc_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next  = state;
    ri_next     = ri;
    cc_next     = cc;
    step_next   = step;
    pixel_ready = 1'b0;
    cmd         = '0;
    cmd.ref_sel  = ri;
    cmd.comp_sel = cc;
    unique case (state)
      ncc_pkg::ST_IDLE: begin
        pixel_ready = 1'b1;
        if (pixel_valid) begin
          cmd.load   = 1'b1;
          state_next = ncc_pkg::ST_LOAD;
        end
      end
      ncc_pkg::ST_LOAD: begin
        ri_next = '0;
        cc_next = ncc_pkg::COMP_RED;
        if (status.empty) begin
          state_next = ncc_pkg::ST_DONE;
        end else begin
          state_next = ncc_pkg::ST_SEARCH;
        end
      end
      ncc_pkg::ST_SEARCH: begin
        cmd.issue = 1'b1;
        unique case (cc)
          ncc_pkg::COMP_RED:   cc_next = ncc_pkg::COMP_GREEN;
          ncc_pkg::COMP_GREEN: cc_next = ncc_pkg::COMP_BLUE;
          default: begin
            cc_next = ncc_pkg::COMP_RED;
            ri_next = ri + 3'd1;
            if (ri == 3'(status.count - 3'd1)) begin
              step_next  = '0;
              state_next = ncc_pkg::ST_DRAIN;
            end
          end
        endcase
      end
      ncc_pkg::ST_DRAIN: begin
        step_next = step + 5'd1;
        if (step == ncc_pkg::DRAIN_STEPS - 5'd1) begin
          state_next = ncc_pkg::ST_PREP;
        end
      end
      ncc_pkg::ST_PREP: begin
        step_next = '0;
        if (status.found) begin
          cmd.sqrt_load = 1'b1;
          state_next    = ncc_pkg::ST_SQRT;
        end else begin
          state_next = ncc_pkg::ST_CHECK;
        end
      end
      ncc_pkg::ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        step_next     = step + 5'd1;
        if (step == ncc_pkg::SQRT_STEPS - 5'd1) begin
          state_next = ncc_pkg::ST_CHECK;
        end
      end
      ncc_pkg::ST_CHECK: begin
        cmd.check  = 1'b1;
        step_next  = '0;
        state_next = ncc_pkg::ST_DIV;
      end
      ncc_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        step_next    = step + 5'd1;
        if (step == ncc_pkg::DIV_STEPS - 5'd1) begin
          state_next = ncc_pkg::ST_DONE;
        end
      end
      ncc_pkg::ST_DONE: begin
        if (status.out_free) begin
          cmd.result_load = 1'b1;
          state_next      = ncc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ncc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/ncc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncc_datapath
// Config registers, distance pipeline, square root, divider and result
// register of the nearest color classifier.
// ----------------------------------------------------------------------------
module ncc_datapath #(
  parameter int NUM_REFS       = ncc_pkg::DEF_NUM_REFS,
  parameter int COMPONENT_BITS = ncc_pkg::DEF_COMPONENT_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [ncc_pkg::IDX_W-1:0]   cfg_index,
  input  logic [ncc_pkg::CFG_W-1:0]   cfg_data,
  input  logic [ncc_pkg::COMP_W-1:0]  red_in,
  input  logic [ncc_pkg::COMP_W-1:0]  green_in,
  input  logic [ncc_pkg::COMP_W-1:0]  blue_in,
  input  ncc_pkg::cmd_t               cmd,
  output ncc_pkg::status_t            status,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic                        matched,
  output logic [ncc_pkg::CNT_W-1:0]   match_index,
  output logic [ncc_pkg::CONF_W-1:0]  confidence
);

  localparam int RI_W        = (NUM_REFS > 1) ? $clog2(NUM_REFS) : 1;
  localparam int ALIGN_SHIFT = ncc_pkg::COMP_W - COMPONENT_BITS;

  function automatic logic [ncc_pkg::COMP_W-1:0] align_comp(
    input logic [ncc_pkg::COMP_W-1:0] v
  );
    align_comp = ncc_pkg::COMP_W'(v[COMPONENT_BITS-1:0]) << ALIGN_SHIFT;
  endfunction

  // config registers
  logic [ncc_pkg::CNT_W-1:0]  ref_count;
  logic [ncc_pkg::CONF_W-1:0] threshold;
  logic [ncc_pkg::CFG_W-1:0]  ref_color [NUM_REFS];
  logic [ncc_pkg::CNT_W-1:0]  widx;

  assign widx = 3'(cfg_index - ncc_pkg::REG_REF_COLOR_0);

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_count <= '0;
      threshold <= ncc_pkg::THR_RESET;
      for (int i = 0; i < NUM_REFS; i++) begin
        ref_color[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        ncc_pkg::REG_REF_COUNT: ref_count <= cfg_data[ncc_pkg::CNT_W-1:0];
        ncc_pkg::REG_THRESHOLD: threshold <= cfg_data[ncc_pkg::CONF_W-1:0];
        default: begin
          if (widx < 3'(NUM_REFS)) begin
            ref_color[widx[RI_W-1:0]] <= cfg_data;
          end
        end
      endcase
    end
  end

  // transaction load
  logic [ncc_pkg::COMP_W-1:0] r_q, g_q, b_q;
  logic [ncc_pkg::MAG_W-1:0]  mag, mag_next;
  logic [ncc_pkg::CNT_W-1:0]  count_sat, count_q;
  logic                       empty_q;

  assign count_sat = (ref_count > 3'(NUM_REFS)) ? 3'(NUM_REFS) : ref_count;
  assign mag_next  = ncc_pkg::MAG_W'(align_comp(red_in))
                   + ncc_pkg::MAG_W'(align_comp(green_in))
                   + ncc_pkg::MAG_W'(align_comp(blue_in));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_q     <= align_comp(red_in);
      g_q     <= align_comp(green_in);
      b_q     <= align_comp(blue_in);
      mag     <= mag_next;
      count_q <= count_sat;
      empty_q <= (mag_next == '0) || (count_sat == '0);
    end
  end

  // distance pipeline: difference, square, accumulate, compare
  logic [ncc_pkg::CFG_W-1:0]  ref_word;
  logic [ncc_pkg::COMP_W-1:0] ref_c, in_c, diff;
  logic [ncc_pkg::COMP_W-1:0] diff_q;
  logic [ncc_pkg::SQ_W-1:0]   sq_q;
  logic [ncc_pkg::ACC_W-1:0]  acc, best;
  logic                       d_valid, d_first, d_last;
  logic                       s_valid, s_first, s_last;
  logic                       c_valid, c_last;
  logic [ncc_pkg::CNT_W-1:0]  d_idx, s_idx, c_idx, best_idx;
  logic                       found;

  assign ref_word = ref_color[cmd.ref_sel[RI_W-1:0]];

  always_comb begin
    case (cmd.comp_sel)
      ncc_pkg::COMP_RED: begin
        ref_c = align_comp(ref_word[47:32]);
        in_c  = r_q;
      end
      ncc_pkg::COMP_GREEN: begin
        ref_c = align_comp(ref_word[31:16]);
        in_c  = g_q;
      end
      default: begin
        ref_c = align_comp(ref_word[15:0]);
        in_c  = b_q;
      end
    endcase
    diff = (ref_c > in_c) ? (ref_c - in_c) : (in_c - ref_c);
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      d_valid <= 1'b0;
      s_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      d_valid <= cmd.issue;
      s_valid <= d_valid;
      c_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    diff_q  <= diff;
    d_first <= (cmd.comp_sel == ncc_pkg::COMP_RED);
    d_last  <= (cmd.comp_sel == ncc_pkg::COMP_BLUE);
    d_idx   <= cmd.ref_sel;
    sq_q    <= {16'b0, diff_q} * {16'b0, diff_q};
    s_first <= d_first;
    s_last  <= d_last;
    s_idx   <= d_idx;
    c_last  <= s_last;
    c_idx   <= s_idx;
    if (s_valid) begin
      acc <= (s_first ? '0 : acc) + ncc_pkg::ACC_W'(sq_q);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      best     <= ncc_pkg::BEST_RESET;
      best_idx <= '0;
      found    <= 1'b0;
    end else if (c_valid && c_last && (acc < best)) begin
      best     <= acc;
      best_idx <= c_idx;
      found    <= 1'b1;
    end
  end

  // square root, one result bit per cycle
  logic [ncc_pkg::SQ_W-1:0]   sq_x;
  logic [17:0]                sq_rem;
  logic [ncc_pkg::COMP_W-1:0] root;
  logic [19:0]                rem_sh, trial;

  assign rem_sh = {sq_rem, sq_x[31:30]};
  assign trial  = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (cmd.sqrt_load) begin
      sq_x   <= best[32:1];
      sq_rem <= '0;
      root   <= '0;
    end else if (cmd.sqrt_step) begin
      sq_x <= {sq_x[29:0], 2'b00};
      if (rem_sh >= trial) begin
        sq_rem <= 18'(rem_sh - trial);
        root   <= {root[14:0], 1'b1};
      end else begin
        sq_rem <= 18'(rem_sh);
        root   <= {root[14:0], 1'b0};
      end
    end
  end

  // range check and restoring divide
  logic [ncc_pkg::CONF_W-1:0] distance;
  logic [ncc_pkg::ACC_W-1:0]  num_wide, lim_wide;
  logic                       ovf;
  logic [ncc_pkg::MAG_W-1:0]  drem;
  logic [ncc_pkg::CONF_W-1:0] dlo, quot;
  logic [ncc_pkg::MAG_W:0]    rs;

  assign distance = found ? {1'b0, root} : ncc_pkg::Q16_ONE;
  assign num_wide = ncc_pkg::ACC_W'({distance, 16'h0000});
  assign lim_wide = ncc_pkg::ACC_W'({mag, 16'h0000}) + ncc_pkg::ACC_W'(mag);
  assign rs       = {drem, dlo[16]};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ovf <= 1'b0;
    end else if (cmd.check) begin
      ovf <= (num_wide >= lim_wide);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      drem <= ncc_pkg::MAG_W'(distance >> 1);
      dlo  <= {distance[0], 16'h0000};
      quot <= '0;
    end else if (cmd.div_step) begin
      dlo <= {dlo[15:0], 1'b0};
      if (rs >= {1'b0, mag}) begin
        drem <= ncc_pkg::MAG_W'(rs - {1'b0, mag});
        quot <= {quot[15:0], 1'b1};
      end else begin
        drem <= ncc_pkg::MAG_W'(rs);
        quot <= {quot[15:0], 1'b0};
      end
    end
  end

  // result register
  logic [ncc_pkg::CONF_W-1:0] conf, thr_sat;
  logic                       hit;

  assign conf    = ncc_pkg::Q16_ONE - quot;
  assign thr_sat = (threshold > ncc_pkg::Q16_ONE) ? ncc_pkg::Q16_ONE : threshold;
  assign hit     = !empty_q && !ovf && (conf > thr_sat);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.result_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      matched     <= hit;
      match_index <= hit ? best_idx : '0;
      confidence  <= hit ? conf : '0;
    end
  end

  assign status.empty    = empty_q;
  assign status.found    = found;
  assign status.out_free = !result_valid || result_ready;
  assign status.count    = count_q;

endmodule

### rtl/core/nearest_color_classifier_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_color_classifier_top
// Finds the nearest configured reference color to an RGB reading and reports
// index and confidence when the confidence clears the threshold.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+----------------------------------
//  pixel    | pixel_valid / pixel_ready  | red_in, green_in, blue_in
//  result   | result_valid / result_ready| matched, match_index, confidence
//  config   | cfg_we                     | cfg_index, cfg_data
//
// result valid after the search of the active refs, the single squarer, the
// 16-step root and the 17-step divide; the root is skipped when no entry is
// within distance one; the pixel input is ready again as result_valid rises
// empty table or zero magnitude: no search, root or divide; load, then final state
// rst is synchronous: config back to defaults, control and result idle
// a pending result holds the next reading in the final state until taken
// ----------------------------------------------------------------------------
module nearest_color_classifier_top #(
  parameter int NUM_REFS       = ncc_pkg::DEF_NUM_REFS,
  parameter int COMPONENT_BITS = ncc_pkg::DEF_COMPONENT_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [ncc_pkg::IDX_W-1:0]   cfg_index,
  input  logic [ncc_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        pixel_valid,
  output logic                        pixel_ready,
  input  logic [ncc_pkg::COMP_W-1:0]  red_in,
  input  logic [ncc_pkg::COMP_W-1:0]  green_in,
  input  logic [ncc_pkg::COMP_W-1:0]  blue_in,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic                        matched,
  output logic [ncc_pkg::CNT_W-1:0]   match_index,
  output logic [ncc_pkg::CONF_W-1:0]  confidence
);

  ncc_pkg::cmd_t    cmd;
  ncc_pkg::status_t status;

  ncc_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .status      (status),
    .cmd         (cmd)
  );

  ncc_datapath #(
    .NUM_REFS       (NUM_REFS),
    .COMPONENT_BITS (COMPONENT_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .red_in       (red_in),
    .green_in     (green_in),
    .blue_in      (blue_in),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .matched      (matched),
    .match_index  (match_index),
    .confidence   (confidence)
  );

`ifndef SYNTHESIS
  a_nomatch_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !matched |-> (match_index == '0) && (confidence == '0))
    else $error("unmatched result carries index or confidence");

  a_match_sane: assert property (@(posedge clk) disable iff (rst)
    result_valid && matched |-> (match_index < 3'(NUM_REFS)) && (confidence != '0))
    else $error("matched result out of range");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_ready |=> !pixel_ready)
    else $error("ready right after accepted transaction");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.result_load |-> status.out_free)
    else $error("result overwritten before taken");
`endif

endmodule

### dv/tb_nearest_color_classifier_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_color_classifier_top
// Drives RGB readings through the classifier under a series of palettes and
// thresholds, predicts each verdict from the programmed palette, and compares
// every result transaction with the oldest predicted one.
// ----------------------------------------------------------------------------
module tb_nearest_color_classifier_top;
  import ncc_pkg::*;

  localparam int LIMIT_CYCLES  = 2_000_000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 225;
  localparam int NREFS         = 6;

  typedef struct packed {
    logic              matched;
    logic [CNT_W-1:0]  index;
    logic [CONF_W-1:0] conf;
  } verdict_t;

  class palette_scoreboard;
    logic [CNT_W-1:0]  count_reg;
    logic [CONF_W-1:0] thr_reg;
    logic [CFG_W-1:0]  colors [NREFS];
    verdict_t          verdicts_due [$];
    int                errors;

    function new();
      count_reg = '0;
      thr_reg = THR_RESET;
      foreach (colors[i]) colors[i] = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == REG_REF_COUNT) begin
        count_reg = data[CNT_W-1:0];
      end else if (idx == REG_THRESHOLD) begin
        thr_reg = data[CONF_W-1:0];
      end else begin
        colors[idx - REG_REF_COLOR_0] = data;
      end
    endfunction

    function longint unsigned sq_gap(logic [COMP_W-1:0] a, logic [COMP_W-1:0] b);
      longint unsigned d;
      d = (a > b) ? 64'(a - b) : 64'(b - a);
      return d * d;
    endfunction

    function longint unsigned int_sqrt(longint unsigned x);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'h4000_0000_0000_0000;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
        if (x >= root + bitv) begin
          x -= root + bitv;
          root = (root >> 1) + bitv;
        end else begin
          root >>= 1;
        end
        bitv >>= 2;
      end
      return root;
    endfunction

    function verdict_t classify(logic [COMP_W-1:0] r, logic [COMP_W-1:0] g,
                                logic [COMP_W-1:0] b);
      verdict_t        v;
      longint unsigned mag, best, s, distance, quot, conf, thr;
      int              n, hit;
      bit              found;
      v = '0;
      mag = 64'(r) + 64'(g) + 64'(b);
      n = (count_reg > NREFS) ? NREFS : int'(count_reg);
      thr = (thr_reg > Q16_ONE) ? 64'(Q16_ONE) : 64'(thr_reg);
      if (mag == 0 || n == 0) return v;
      best = 64'(BEST_RESET);
      hit = 0;
      found = 0;
      for (int i = 0; i < n; i++) begin
        s = sq_gap(colors[i][47:32], r) + sq_gap(colors[i][31:16], g)
          + sq_gap(colors[i][15:0], b);
        if (s < best) begin
          best = s;
          hit = i;
          found = 1;
        end
      end
      distance = found ? int_sqrt(best >> 1) : 64'(Q16_ONE);
      quot = (distance * 64'(Q16_ONE)) / mag;
      if (quot > 64'(Q16_ONE)) return v;
      conf = 64'(Q16_ONE) - quot;
      if (conf > thr) begin
        v.matched = 1'b1;
        v.index = hit[CNT_W-1:0];
        v.conf = conf[CONF_W-1:0];
      end
      return v;
    endfunction

    function void note_pixel(logic [COMP_W-1:0] r, logic [COMP_W-1:0] g,
                             logic [COMP_W-1:0] b);
      verdicts_due.insert(verdicts_due.size(), classify(r, g, b));
    endfunction

    function void check_result(logic m, logic [CNT_W-1:0] idx, logic [CONF_W-1:0] conf);
      verdict_t want;
      if (verdicts_due.size() == 0) begin
        $display("%0t: unexpected result transaction matched=%0d index=%0d confidence=%0d",
                 $time, m, idx, conf);
        errors++;
        return;
      end
      want = verdicts_due.pop_front();
      if (m !== want.matched || idx !== want.index || conf !== want.conf) begin
        $display("%0t: mismatch expected matched=%0d index=%0d confidence=%0d, got %0d %0d %0d",
                 $time, want.matched, want.index, want.conf, m, idx, conf);
        errors++;
      end
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data = '0;
  logic              pixel_valid = 1'b0;
  logic              pixel_ready;
  logic [COMP_W-1:0] red_in = '0;
  logic [COMP_W-1:0] green_in = '0;
  logic [COMP_W-1:0] blue_in = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  logic              matched;
  logic [CNT_W-1:0]  match_index;
  logic [CONF_W-1:0] confidence;

  palette_scoreboard sb;
  logic [CFG_W-1:0]  palette [NREFS];
  logic [CFG_W-1:0]  count_word;
  logic [CFG_W-1:0]  thr_word;
  bit                quiet = 1'b0;
  int                rx_stall = 0;
  int                cycles = 0;

  nearest_color_classifier_top dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .red_in       (red_in),
    .green_in     (green_in),
    .blue_in      (blue_in),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .matched      (matched),
    .match_index  (match_index),
    .confidence   (confidence)
  );

  always #5 clk = ~clk;

  initial sb = new();

  function automatic int next_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [COMP_W-1:0] pick_comp();
    int roll;
    roll = $urandom_range(0, 7);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return COMP_W'($urandom);
  endfunction

  function automatic logic [COMP_W-1:0] jitter(logic [COMP_W-1:0] base, int span);
    int v;
    v = int'(base) + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[COMP_W-1:0];
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // pixel transaction monitor
  always @(posedge clk) begin
    if (pixel_valid && pixel_ready) sb.note_pixel(red_in, green_in, blue_in);
  end

  // result transaction check and receiver stalls
  always @(posedge clk) begin
    if (result_valid && result_ready) sb.check_result(matched, match_index, confidence);
    if (rx_stall > 0) begin
      result_ready <= 1'b0;
      rx_stall--;
    end else begin
      result_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) rx_stall = next_gap();
    end
  end

  task automatic send_rgb(input logic [COMP_W-1:0] r, input logic [COMP_W-1:0] g,
                          input logic [COMP_W-1:0] b);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_valid <= 1'b1;
    red_in <= r;
    green_in <= g;
    blue_in <= b;
    @(posedge clk);
    while (!pixel_ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    pixel_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic load_palette();
    write_reg(REG_REF_COUNT, count_word);
    write_reg(REG_THRESHOLD, thr_word);
    for (int i = 0; i < NREFS; i++) write_reg(REG_REF_COLOR_0 + IDX_W'(i), palette[i]);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int                active, roll, span;
    logic [CFG_W-1:0]  base;
    logic [CNT_W-1:0]  cnt3;
    logic [CONF_W-1:0] thr17;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // empty table after reset
    send_rgb(16'h0000, 16'h0000, 16'h0000);
    send_rgb(16'hFFFF, 16'hFFFF, 16'hFFFF);
    wait_idle();

    // primaries, black, white and a duplicated entry
    count_word = {45'h1FFF_FFFF_FFFF, 3'd6};
    thr_word = {31'h7FFF_FFFF, 17'd0};
    palette[0] = 48'h0000_0000_0000;
    palette[1] = 48'hFFFF_FFFF_FFFF;
    palette[2] = 48'hFFFF_0000_0000;
    palette[3] = 48'h0000_FFFF_0000;
    palette[4] = 48'h0000_0000_FFFF;
    palette[5] = 48'h0000_0000_FFFF;
    load_palette();
    send_rgb(16'h0000, 16'h0000, 16'h0000);
    send_rgb(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_rgb(16'hFFFF, 16'h0000, 16'h0000);
    send_rgb(16'h0000, 16'hFFFF, 16'h0000);
    send_rgb(16'h0000, 16'h0000, 16'hFFFF);
    send_rgb(16'h0001, 16'h0000, 16'h0000);
    send_rgb(16'h8000, 16'h8000, 16'h8000);
    wait_idle();

    // single white entry, default threshold: out of range and negative confidence
    count_word = 48'd1;
    thr_word = 48'd62259;
    palette[0] = 48'hFFFF_FFFF_FFFF;
    load_palette();
    send_rgb(16'h0001, 16'h0001, 16'h0001);
    send_rgb(16'hFFFF, 16'hFFFF, 16'hF000);
    send_rgb(16'hFFFF, 16'h0000, 16'h0000);
    send_rgb(16'h0000, 16'h0000, 16'h0001);
    wait_idle();

    // count and threshold above range
    count_word = 48'd7;
    thr_word = 48'h1FFFF;
    load_palette();
    send_rgb(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_rgb(16'hFFFF, 16'h0000, 16'h0000);
    wait_idle();

    count_word = 48'd3;
    thr_word = 48'd65535;
    load_palette();
    send_rgb(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_rgb(16'hFFFE, 16'hFFFF, 16'hFFFF);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      roll = $urandom_range(0, 9);
      if (roll == 0) cnt3 = 3'd0;
      else if (roll == 1) cnt3 = 3'd7;
      else cnt3 = CNT_W'($urandom_range(1, NREFS));
      case ($urandom_range(0, 5))
        0: thr17 = '0;
        1: thr17 = Q16_ONE;
        2: thr17 = '1;
        3: thr17 = CONF_W'($urandom_range(0, 65536));
        default: thr17 = CONF_W'($urandom_range(58000, 65535));
      endcase
      count_word = {45'({$urandom, $urandom}), cnt3};
      thr_word = {31'($urandom), thr17};
      for (int i = 0; i < NREFS; i++) palette[i] = {pick_comp(), pick_comp(), pick_comp()};
      quiet = (ph % 3 == 2);
      load_palette();
      active = (cnt3 > NREFS) ? NREFS : int'(cnt3);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        roll = $urandom_range(0, 99);
        if (active > 0 && roll < 78) begin
          base = palette[$urandom_range(0, active - 1)];
          span = $urandom_range(0, 9);
          span = (roll >= 70) ? 0 : (span < 5) ? 15 : (span < 8) ? 255 : 4095;
          send_rgb(jitter(base[47:32], span), jitter(base[31:16], span),
                   jitter(base[15:0], span));
        end else if (roll < 81) begin
          send_rgb(16'h0000, 16'h0000, 16'h0000);
        end else begin
          send_rgb(pick_comp(), pick_comp(), pick_comp());
        end
      end
    end

    wait_idle();
    quiet = 1'b0;
    repeat (100) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/ncc_pkg.sv
rtl/core/ncc_ctrl.sv
rtl/core/ncc_datapath.sv
rtl/core/nearest_color_classifier_top.sv
dv/tb_nearest_color_classifier_top.sv
